/* rtl/mpbr_pkg.sv */
// ----------------------------------------------------------------------------
// mpbr_pkg : shared types and constants for the brake-ramp motor driver
// Command codes, datapath widths and reciprocal constants for the
// divide-by-constant steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpbr_pkg;

    localparam int VELOCITY_BITS = 16;
    localparam int MAG_BITS      = VELOCITY_BITS + 1;  // |v| incl. most negative value
    localparam int QUO_BITS      = MAG_BITS - 6;       // |v| / 100 fits here
    localparam int TDATA_IN_BITS = ((VELOCITY_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_BITS = 16;                // duty, two pin bits and braking flag, byte padded
    localparam int DUTY_BITS     = 8;
    localparam int PERIOD_BITS   = 6;
    localparam int REM_BITS      = 7;

    // Command codes carried on tuser
    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // x / 100 by reciprocal; shift chosen so the error stays below one
    // hundredth over the whole magnitude range
    localparam int    DIV100_SHIFT = MAG_BITS + 7;
    localparam int    DIV100_BITS  = DIV100_SHIFT - 6;
    localparam longint DIV100_MULT = ((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100;
    localparam int    DIV100_PROD  = MAG_BITS + DIV100_BITS;

    // (r * 255) / 100 for r < 100
    localparam int    DUTY_SHIFT = 22;
    localparam longint DUTY_MULT = ((64'd1 << DUTY_SHIFT) + 64'd99) / 64'd100;

    // n / 5 for n < 260
    localparam int RECIP5_MULT  = 205;
    localparam int RECIP5_SHIFT = 10;

    // Registered command, as handed from the input stage to the control stage
    typedef struct packed {
        logic [1:0]             op;
        logic                   fwd;
        logic [MAG_BITS-1:0]    mag;
        logic [QUO_BITS-1:0]    quo;
        logic [PERIOD_BITS-1:0] period;
    } front_t;

endpackage

/* rtl/mpbr_front.sv */
// ----------------------------------------------------------------------------
// mpbr_front : input register stage
// Takes a command, forms |v|, the direction, |v| / 100 and the ramp step
// period, and holds them for the control stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpbr_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mpbr_pkg::TDATA_IN_BITS-1:0] s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              take,
    output logic                              cmd_valid,
    output mpbr_pkg::front_t                  cmd
);
    import mpbr_pkg::*;

    logic                         valid_reg;
    front_t                       cmd_reg;
    front_t                       cmd_next;
    logic signed [VELOCITY_BITS-1:0] vel;
    logic [MAG_BITS-1:0]          vel_ext;
    logic [DIV100_PROD-1:0]       quo_prod;
    logic [7:0]                   mag_sat;
    logic [8:0]                   ceil5_arg;
    logic [16:0]                  ceil5_prod;
    logic [PERIOD_BITS-1:0]       ceil5;
    logic [PERIOD_BITS-1:0]       period;

    assign s_tready = !valid_reg || take;

    assign vel     = s_tdata[VELOCITY_BITS-1:0];
    assign vel_ext = {vel[VELOCITY_BITS-1], vel};

    // floor(|v| / 100) by reciprocal multiply
    assign quo_prod = DIV100_PROD'(cmd_next.mag) * DIV100_PROD'(DIV100_MULT);

    // Step period: only small magnitudes matter, all above 135 clamp to 1
    assign mag_sat    = (cmd_next.mag > MAG_BITS'(255)) ? 8'd255 : cmd_next.mag[7:0];
    assign ceil5_arg  = {1'b0, mag_sat} + 9'd4;
    assign ceil5_prod = 17'(ceil5_arg) * 17'(RECIP5_MULT);
    assign ceil5      = ceil5_prod[RECIP5_SHIFT +: PERIOD_BITS];

    always_comb begin
        if (mag_sat < 8'd20) begin
            period = PERIOD_BITS'(2);
        end else if (mag_sat <= 8'd30) begin
            period = mag_sat[PERIOD_BITS-1:0];
        end else if (mag_sat < 8'd65) begin
            period = PERIOD_BITS'(48) - PERIOD_BITS'((9'(mag_sat) + 9'd1) >> 1);
        end else if (ceil5 < PERIOD_BITS'(28)) begin
            period = PERIOD_BITS'(28) - ceil5;
        end else begin
            period = PERIOD_BITS'(1);
        end
    end

    always_comb begin
        cmd_next.op     = s_tuser;
        cmd_next.fwd    = !vel[VELOCITY_BITS-1] && (vel != '0);
        cmd_next.mag    = vel[VELOCITY_BITS-1] ? (~vel_ext + MAG_BITS'(1)) : vel_ext;
        cmd_next.quo    = quo_prod[DIV100_SHIFT +: QUO_BITS];
        cmd_next.period = period;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

/* rtl/mpbr_ctrl.sv */
// ----------------------------------------------------------------------------
// mpbr_ctrl : bridge state, braking ramp and result register
// Applies one registered command to the driver state and registers the
// resulting duty, bridge levels and braking flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpbr_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cmd_valid,
    input  mpbr_pkg::front_t                   cmd,
    output logic                               take,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mpbr_pkg::TDATA_OUT_BITS-1:0] m_tdata
);
    import mpbr_pkg::*;

    // stored velocity, kept as its start duty, period and direction
    logic [DUTY_BITS-1:0]   spd_duty_reg,   spd_duty_next;
    logic [PERIOD_BITS-1:0] spd_period_reg, spd_period_next;
    logic                   spd_fwd_reg,    spd_fwd_next;
    // driven outputs and ramp
    logic [DUTY_BITS-1:0]   duty_reg,   duty_next;
    logic [1:0]             pins_reg,   pins_next;     // bit0 drive_a, bit1 drive_b
    logic                   active_reg, active_next;
    logic [DUTY_BITS-1:0]   level_reg,  level_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [PERIOD_BITS-1:0] tick_reg,   tick_next;
    logic                   out_valid_reg;
    logic [TDATA_OUT_BITS-1:0] out_data_reg;

    logic [MAG_BITS-1:0]    rem_wide;
    logic [MAG_BITS-1:0]    rem_fix;
    logic [REM_BITS-1:0]    rem;
    logic [14:0]            duty_num;
    logic [30:0]            duty_prod;
    logic [DUTY_BITS-1:0]   duty_new;
    logic [PERIOD_BITS-1:0] tick_inc;

    assign take = !out_valid_reg || m_tready;

    // |v| mod 100, quotient comes in already formed
    assign rem_wide = cmd.mag - MAG_BITS'(MAG_BITS'(cmd.quo) * MAG_BITS'(100));
    assign rem_fix  = (rem_wide >= MAG_BITS'(100)) ? rem_wide - MAG_BITS'(100) : rem_wide;
    assign rem      = rem_fix[REM_BITS-1:0];

    // duty = floor(rem * 255 / 100)
    assign duty_num  = {rem, 8'd0} - 15'(rem);
    assign duty_prod = 31'(duty_num) * 31'(DUTY_MULT);
    assign duty_new  = duty_prod[DUTY_SHIFT +: DUTY_BITS];

    assign tick_inc = tick_reg + PERIOD_BITS'(1);

    always_comb begin
        spd_duty_next   = spd_duty_reg;
        spd_period_next = spd_period_reg;
        spd_fwd_next    = spd_fwd_reg;
        duty_next       = duty_reg;
        pins_next       = pins_reg;
        active_next     = active_reg;
        level_next      = level_reg;
        period_next     = period_reg;
        tick_next       = tick_reg;
        case (cmd.op)
            OP_SET: begin
                if (!active_reg) begin
                    spd_duty_next   = duty_new;
                    spd_period_next = cmd.period;
                    spd_fwd_next    = cmd.fwd;
                    duty_next       = duty_new;
                    pins_next       = {cmd.fwd, !cmd.fwd};
                end
            end
            OP_STOP: begin
                if (!active_reg) begin
                    if (spd_duty_reg == '0) begin
                        spd_fwd_next = 1'b0;       // velocity cleared, pins left alone
                    end else begin
                        active_next = 1'b1;
                        level_next  = spd_duty_reg - DUTY_BITS'(1);
                        duty_next   = spd_duty_reg - DUTY_BITS'(1);
                        pins_next   = {!spd_fwd_reg, spd_fwd_reg};
                        period_next = spd_period_reg;
                        tick_next   = '0;
                    end
                end
            end
            OP_TICK: begin
                if (active_reg) begin
                    if (tick_inc >= period_reg) begin
                        tick_next = '0;
                        if (level_reg == '0) begin
                            active_next   = 1'b0;
                            spd_duty_next = '0;
                            spd_fwd_next  = 1'b0;
                        end else begin
                            level_next = level_reg - DUTY_BITS'(1);
                            duty_next  = level_reg - DUTY_BITS'(1);
                        end
                    end else begin
                        tick_next = tick_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_duty_reg   <= '0;
            spd_period_reg <= '0;
            spd_fwd_reg    <= 1'b0;
            duty_reg       <= '0;
            pins_reg       <= '0;
            active_reg     <= 1'b0;
            level_reg      <= '0;
            period_reg     <= '0;
            tick_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else if (take) begin
            out_valid_reg <= cmd_valid;
            if (cmd_valid) begin
                spd_duty_reg   <= spd_duty_next;
                spd_period_reg <= spd_period_next;
                spd_fwd_reg    <= spd_fwd_next;
                duty_reg       <= duty_next;
                pins_reg       <= pins_next;
                active_reg     <= active_next;
                level_reg      <= level_next;
                period_reg     <= period_next;
                tick_reg       <= tick_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && cmd_valid) begin
            out_data_reg <= TDATA_OUT_BITS'({active_next, pins_next[1], pins_next[0], duty_next});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_ramp_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (duty_reg == level_reg))
        else $error("ramp duty differs from ramp level");

    a_ramp_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> $onehot(pins_reg))
        else $error("bridge not driven one-sided during ramp");

    a_ramp_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> ((period_reg != '0) && (tick_reg < period_reg)))
        else $error("ramp tick count out of range");

    a_ramp_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) |-> ((duty_reg == '0) && (spd_duty_reg == '0)))
        else $error("ramp ended with duty or velocity left");
`endif

endmodule

/* rtl/motor_pwm_brake_ramp_core.sv */
// ----------------------------------------------------------------------------
// motor_pwm_brake_ramp_core : H-bridge PWM driver with braking ramp
// Set stores a velocity and drives duty and bridge direction, but is ignored
// during a ramp; stop runs a reversed-bridge ramp down to zero, stepped by millisecond tick commands.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (lsb up)                       | tuser
//  --------+-----+--------------------------------------+-------------------
//  s_      | in  | velocity[15:0] signed                | op[1:0]
//  m_      | out | duty[7:0] drive_a drive_b braking, 0 | -
//
//  Each command gives one result transaction showing the state after it.
//  A command passes the input register, then the state update into the result
//  register; one transaction per cycle sustained while m_tready is high, limited by
//  the single state-update stage.
//  aresetn (synchronous, active low) clears both stages and all driver state.
//  m_tready low holds the result; if the input register is empty one more
//  command is still taken into it, otherwise s_tready drops in the same cycle.
//
`timescale 1ns / 1ps

module motor_pwm_brake_ramp_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // command channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mpbr_pkg::TDATA_IN_BITS-1:0]  s_tdata,   // velocity
    input  logic [1:0]                          s_tuser,   // op
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mpbr_pkg::TDATA_OUT_BITS-1:0] m_tdata    // duty, drive_a, drive_b, braking
);
    import mpbr_pkg::*;

    logic   take;        // control stage can absorb the held command
    logic   cmd_valid;
    front_t cmd;

    // Input register: magnitude, direction, /100 quotient, ramp period
    mpbr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .take      (take),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // Driver state, ramp sequencing and result register
    mpbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
